[rtl/core/chained_free_block_list_assert.svh]
// Assertion macros shared by the chained free-block list RTL.
`ifndef CHAINED_FREE_BLOCK_LIST_ASSERT_SVH
`define CHAINED_FREE_BLOCK_LIST_ASSERT_SVH
`ifndef ASSERT_OFF
`define CFBL_ASSERT_IMP(label, ante, cons) label: assert property ( \
	@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("same-cycle check failed");
`define CFBL_ASSERT_NXT(label, ante, cons) label: assert property ( \
	@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("next-cycle check failed");
`else
`define CFBL_ASSERT_IMP(label, ante, cons)
`define CFBL_ASSERT_NXT(label, ante, cons)
`endif
`endif

[rtl/core/cfbl_pkg.sv]
// Package with constants, codes and the sequencer state type of the free-block list.
package cfbl_pkg;

	localparam int unsigned LIST_CAPACITY_DEF = 64;
	localparam int unsigned NUM_BLOCKS_DEF = 1024;
	localparam int BLOCK_W = 10;

	localparam logic OP_FREE = 1'b0;
	localparam logic OP_ALLOC = 1'b1;

	localparam logic STATUS_OK = 1'b0;
	localparam logic STATUS_EMPTY = 1'b1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_POP,
		S_SPILL,
		S_REFILL,
		S_DONE
	} state_t;

endpackage

[rtl/core/chained_free_block_list.sv]
// Chained free-block list allocator with head stack and chain store memories.
//
// The request channel (req_valid, req_stall, operation, block_number) takes one
// transaction at a time: operation 0 frees block_number, operation 1 allocates.
// The response channel (rsp_valid, rsp_stall, allocated_block, status) returns
// exactly one transaction per request, in order. A failed allocate gives
// status 1 and block 0; a free always gives status 0 and block 0.
// A free, or an allocate on an empty list, passes S_EXEC and then S_DONE
// before rsp_valid rises; any other allocate passes S_POP between them. A new
// request is taken only once the last response is in the output register.
// A free of an in-range block onto a full stack spills the stack into the
// chain store, and an allocate that empties the stack refills it, in S_SPILL
// or S_REFILL, one entry per cycle through the single port of each memory.
// req_stall is high from the accepting edge until the response is loaded into
// the output register. The output register holds its transaction while
// rsp_stall is high; a finished result waits in the sequencer until the
// register is free. Reset clears the head count, so the list starts empty;
// both memories start undefined and need no clearing pass.
module chained_free_block_list #(
	parameter int unsigned LIST_CAPACITY = cfbl_pkg::LIST_CAPACITY_DEF,
	parameter int unsigned NUM_BLOCKS = cfbl_pkg::NUM_BLOCKS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         req_valid,
	output logic                         req_stall,
	input  logic                         operation,
	input  logic [cfbl_pkg::BLOCK_W-1:0] block_number,
	output logic                         rsp_valid,
	input  logic                         rsp_stall,
	output logic [cfbl_pkg::BLOCK_W-1:0] allocated_block,
	output logic                         status
);

	localparam int BW = cfbl_pkg::BLOCK_W;
	localparam int SAW = $clog2(LIST_CAPACITY);
	localparam int CW = $clog2(LIST_CAPACITY + 1);
	localparam int unsigned CDEPTH = NUM_BLOCKS * LIST_CAPACITY;
	localparam int CAW = $clog2(CDEPTH);
	localparam logic [CW-1:0] CAP = CW'(LIST_CAPACITY);
	localparam logic [CW-1:0] ONE = CW'(1);

	cfbl_pkg::state_t state_q, state_next;

	logic [CW-1:0]  count_q;
	logic [CW-1:0]  step_q;
	logic [CW-1:0]  step_m1;
	logic [CAW-1:0] base_q;
	logic           op_q;
	logic [BW-1:0]  blk_q;
	logic [BW-1:0]  res_blk_q;
	logic           res_st_q;
	logic           rsp_valid_q;
	logic [BW-1:0]  allocated_block_q;
	logic           status_q;

	logic [BW-1:0]  head_mem [LIST_CAPACITY];
	logic [BW-1:0]  chain_mem [CDEPTH];
	logic [BW-1:0]  head_rd_q;
	logic [BW-1:0]  chain_rd_q;

	logic           head_re, head_we, chain_re, chain_we;
	logic [SAW-1:0] head_raddr, head_waddr;
	logic [BW-1:0]  head_wdata;
	logic [CAW-1:0] chain_raddr, chain_waddr;

	logic           blk_in_range;
	logic           top_ok;
	logic           out_free;
	logic [CAW-1:0] blk_base;
	logic [CAW-1:0] top_base;

	assign step_m1 = step_q - ONE;
	assign blk_in_range = 32'(blk_q) < NUM_BLOCKS;
	assign top_ok = (head_rd_q != '0) && (32'(head_rd_q) < NUM_BLOCKS);
	assign out_free = !rsp_valid_q || !rsp_stall;
	assign blk_base = CAW'(32'(blk_q) * LIST_CAPACITY);
	assign top_base = CAW'(32'(head_rd_q) * LIST_CAPACITY);

	always_comb begin
		state_next = state_q;
		case (state_q)
			cfbl_pkg::S_IDLE: begin
				if (req_valid) begin
					state_next = cfbl_pkg::S_EXEC;
				end
			end
			cfbl_pkg::S_EXEC: begin
				if (op_q == cfbl_pkg::OP_FREE) begin
					if (blk_in_range && count_q == CAP) begin
						state_next = cfbl_pkg::S_SPILL;
					end else begin
						state_next = cfbl_pkg::S_DONE;
					end
				end else if (count_q == '0) begin
					state_next = cfbl_pkg::S_DONE;
				end else begin
					state_next = cfbl_pkg::S_POP;
				end
			end
			cfbl_pkg::S_POP: begin
				if (top_ok && count_q == ONE) begin
					state_next = cfbl_pkg::S_REFILL;
				end else begin
					state_next = cfbl_pkg::S_DONE;
				end
			end
			cfbl_pkg::S_SPILL, cfbl_pkg::S_REFILL: begin
				if (step_q == CAP) begin
					state_next = cfbl_pkg::S_DONE;
				end
			end
			cfbl_pkg::S_DONE: begin
				if (out_free) begin
					state_next = cfbl_pkg::S_IDLE;
				end
			end
			default: begin
				state_next = cfbl_pkg::S_IDLE;
			end
		endcase
	end

	always_comb begin
		req_stall = state_q != cfbl_pkg::S_IDLE;
		head_re = 1'b0;
		head_raddr = step_q[SAW-1:0];
		head_we = 1'b0;
		head_waddr = count_q[SAW-1:0];
		head_wdata = blk_q;
		chain_re = 1'b0;
		chain_raddr = base_q + CAW'(step_q);
		chain_we = 1'b0;
		chain_waddr = base_q + CAW'(step_m1);
		case (state_q)
			cfbl_pkg::S_EXEC: begin
				if (op_q == cfbl_pkg::OP_FREE) begin
					head_we = blk_in_range && count_q != CAP;
				end else begin
					head_re = count_q != '0;
					head_raddr = SAW'(count_q - ONE);
				end
			end
			cfbl_pkg::S_SPILL: begin
				head_re = step_q != CAP;
				chain_we = step_q != '0;
				if (step_q == CAP) begin
					head_we = 1'b1;
					head_waddr = '0;
				end
			end
			cfbl_pkg::S_REFILL: begin
				chain_re = step_q != CAP;
				head_we = step_q != '0;
				head_waddr = step_m1[SAW-1:0];
				head_wdata = chain_rd_q;
			end
			default: begin
				head_re = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cfbl_pkg::S_IDLE;
			count_q <= '0;
			step_q <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			case (state_q)
				cfbl_pkg::S_EXEC: begin
					step_q <= '0;
					if (op_q == cfbl_pkg::OP_FREE && blk_in_range && count_q != CAP) begin
						count_q <= count_q + ONE;
					end
				end
				cfbl_pkg::S_POP: begin
					if (top_ok) begin
						count_q <= count_q - ONE;
					end
				end
				cfbl_pkg::S_SPILL: begin
					step_q <= step_q + ONE;
					if (step_q == CAP) begin
						count_q <= ONE;
					end
				end
				cfbl_pkg::S_REFILL: begin
					step_q <= step_q + ONE;
					if (step_q == CAP) begin
						count_q <= CAP;
					end
				end
				default: begin
					step_q <= step_q;
				end
			endcase
			if (state_q == cfbl_pkg::S_DONE && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == cfbl_pkg::S_IDLE && req_valid) begin
			op_q <= operation;
			blk_q <= block_number;
		end
		case (state_q)
			cfbl_pkg::S_EXEC: begin
				base_q <= blk_base;
				res_blk_q <= '0;
				if (op_q == cfbl_pkg::OP_ALLOC && count_q == '0) begin
					res_st_q <= cfbl_pkg::STATUS_EMPTY;
				end else begin
					res_st_q <= cfbl_pkg::STATUS_OK;
				end
			end
			cfbl_pkg::S_POP: begin
				base_q <= top_base;
				if (top_ok) begin
					res_blk_q <= head_rd_q;
					res_st_q <= cfbl_pkg::STATUS_OK;
				end else begin
					res_blk_q <= '0;
					res_st_q <= cfbl_pkg::STATUS_EMPTY;
				end
			end
			default: begin
				res_blk_q <= res_blk_q;
			end
		endcase
		if (state_q == cfbl_pkg::S_DONE && out_free) begin
			allocated_block_q <= res_blk_q;
			status_q <= res_st_q;
		end
	end

	always_ff @(posedge clk) begin
		if (head_we) begin
			head_mem[head_waddr] <= head_wdata;
		end
		if (head_re) begin
			head_rd_q <= head_mem[head_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (chain_we) begin
			chain_mem[chain_waddr] <= head_rd_q;
		end
		if (chain_re) begin
			chain_rd_q <= chain_mem[chain_raddr];
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign allocated_block = allocated_block_q;
	assign status = status_q;

`include "chained_free_block_list_assert.svh"

	`CFBL_ASSERT_IMP(a_count_bound, 1'b1, count_q <= CAP)
	`CFBL_ASSERT_IMP(a_empty_gives_zero, rsp_valid && status == cfbl_pkg::STATUS_EMPTY, allocated_block == '0)
	`CFBL_ASSERT_IMP(a_spill_only_full, state_q == cfbl_pkg::S_SPILL, count_q == CAP)
	`CFBL_ASSERT_IMP(a_refill_only_empty, state_q == cfbl_pkg::S_REFILL, count_q == '0)
	`CFBL_ASSERT_NXT(a_busy_after_accept, req_valid && !req_stall, req_stall)

endmodule
